// ===== rtl/ifsd_pkg.sv =====
`default_nettype none
package ifsd_pkg;

  localparam int FRAME_BYTES = 30;
  localparam logic [7:0] HEADER_BYTE = 8'h5A;

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  // The byte that arrives with the last one of a frame plus the chain behind it must
  // reach back to frame byte 4, the first decoded byte.
  localparam int FIRST_DECODED = 4;
  localparam int CHAIN_CELLS = FRAME_BYTES - 1 - FIRST_DECODED;
  localparam int VIEW_N = CHAIN_CELLS + 1;
  localparam int VIEW_W = $clog2(VIEW_N);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_MARK,
    ST_COLLECT
  } ifsd_state_t;

  typedef struct packed {
    logic collecting;
    logic frame_done;
  } ifsd_ctrl_t;

  // Signed divide by 16, truncating toward zero.
  function automatic logic signed [11:0] div16(input logic [15:0] w);
    logic signed [16:0] t;
    t = $signed({w[15], w}) + (w[15] ? 17'sd15 : 17'sd0);
    return t[15:4];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ifsd_byte_if.sv =====
`default_nettype none
interface ifsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/ifsd_rec_if.sv =====
`default_nettype none
interface ifsd_rec_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [11:0] mag_x;
  logic signed [11:0] mag_y;
  logic signed [11:0] mag_z;
  logic signed [11:0] rate_x;
  logic signed [11:0] rate_y;
  logic signed [11:0] rate_z;
  logic        [15:0] yaw_centideg;
  logic signed [15:0] roll_centideg;
  logic signed [15:0] pitch_centideg;

  modport source (
    output valid, input ready,
    output acc_x, output acc_y, output acc_z,
    output mag_x, output mag_y, output mag_z,
    output rate_x, output rate_y, output rate_z,
    output yaw_centideg, output roll_centideg, output pitch_centideg
  );
  modport sink (
    input valid, output ready,
    input acc_x, input acc_y, input acc_z,
    input mag_x, input mag_y, input mag_z,
    input rate_x, input rate_y, input rate_z,
    input yaw_centideg, input roll_centideg, input pitch_centideg
  );
endinterface
`default_nettype wire

// ===== rtl/ifsd_cell.sv =====
`default_nettype none
module ifsd_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] byte_in,
  output logic      [7:0] byte_out
);
  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
endmodule
`default_nettype wire

// ===== rtl/ifsd_sync.sv =====
`default_nettype none
module ifsd_sync (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic [7:0]              rx_byte,
  output ifsd_pkg::ifsd_ctrl_t         ctrl
);
  import ifsd_pkg::*;

  ifsd_state_t      state;
  ifsd_state_t      state_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             is_header;
  logic             at_last;

  assign is_header = (rx_byte == HEADER_BYTE);
  assign at_last   = (pos == POS_LAST);

  always_comb begin
    state_next = state;
    pos_next   = pos;
    if (accept) begin
      unique case (state)
        ST_HUNT: begin
          if (is_header) state_next = ST_MARK;
        end
        ST_MARK: begin
          if (is_header) begin
            state_next = ST_COLLECT;
            pos_next   = POS_FIRST_DATA;
          end else begin
            state_next = ST_HUNT;
          end
        end
        ST_COLLECT: begin
          if (at_last) begin
            state_next = ST_HUNT;
            pos_next   = '0;
          end else begin
            pos_next = pos + POS_W'(1);
          end
        end
        default: state_next = ST_HUNT;
      endcase
    end
  end

  always_comb begin
    ctrl.collecting = (state == ST_COLLECT);
    ctrl.frame_done = accept && (state == ST_COLLECT) && at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/imu_frame_sync_decoder.sv =====
`default_nettype none
// Frame-sync decoder for a serial inertial sensor link. Takes one received byte per
// cycle, hunts for a 0x5A 0x5A header and collects a 30-byte frame, header included.
// Every accepted byte moves down a row of byte cells; on the last byte of a frame the
// record is decoded from the cells plus that byte and loaded into the output register,
// so the record is offered the cycle after the last byte. Throughput is one byte per
// cycle; the input stalls only while a finished record waits to be taken. No checksum
// is checked, and angles stay in hundredths of a degree.
module imu_frame_sync_decoder (
  input  wire logic clk,
  input  wire logic rst,
  ifsd_byte_if.sink rx,
  ifsd_rec_if.source rec
);
  import ifsd_pkg::*;

  logic       accept;
  ifsd_ctrl_t ctrl;
  logic [7:0] view [VIEW_N];
  logic       rec_valid;

  assign rx.ready = !rec_valid || rec.ready;
  assign accept   = rx.valid && rx.ready;

  ifsd_sync u_sync (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .ctrl    (ctrl)
  );

  // view[0] is the arriving byte, view[k] the cell k-1 places down the chain.
  assign view[0] = rx.rx_byte;

  for (genvar k = 0; k < CHAIN_CELLS; k++) begin : g_cell
    ifsd_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .byte_in  (view[k]),
      .byte_out (view[k+1])
    );
  end

  function automatic logic [15:0] word_at(input int idx);
    return {view[VIEW_W'(FRAME_BYTES - 1 - idx)], view[VIEW_W'(FRAME_BYTES - 2 - idx)]};
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.frame_done) begin
      rec.acc_x          <= word_at(4);
      rec.acc_y          <= word_at(6);
      rec.acc_z          <= word_at(8);
      rec.mag_x          <= div16(word_at(10));
      rec.mag_y          <= div16(word_at(12));
      rec.mag_z          <= div16(word_at(14));
      rec.rate_x         <= div16(word_at(16));
      rec.rate_y         <= div16(word_at(18));
      rec.rate_z         <= div16(word_at(20));
      rec.yaw_centideg   <= word_at(22);
      rec.roll_centideg  <= word_at(24);
      rec.pitch_centideg <= word_at(26);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (ctrl.frame_done) begin
      rec_valid <= 1'b1;
    end else if (rec.ready) begin
      rec_valid <= 1'b0;
    end
  end

  assign rec.valid = rec_valid;

  a_done_in_frame: assert property (@(posedge clk) disable iff (rst)
    ctrl.frame_done |-> ctrl.collecting && accept)
    else $error("frame end outside a frame");

  a_rise_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rec.valid) |-> $past(ctrl.frame_done))
    else $error("record appeared without a finished frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.frame_done |-> !rec_valid || rec.ready)
    else $error("waiting record overwritten");
endmodule
`default_nettype wire
